>>> hw/rtl/sad_pkg.sv
// Shared types and constants for the serial API exchange detector.
package sad_pkg;

	// Raw codes of the kind field
	localparam logic [2:0] KIND_DEV_BYTE  = 3'd0;
	localparam logic [2:0] KIND_HOST_BYTE = 3'd1;
	localparam logic [2:0] KIND_TIME      = 3'd2;
	localparam logic [2:0] KIND_TAKE_ACK  = 3'd3;
	localparam logic [2:0] KIND_SOFT_RST  = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_START_BYTE    = 3'd0;
	localparam logic [2:0] CFG_MIN_LENGTH    = 3'd1;
	localparam logic [2:0] CFG_CHECKSUM_SEED = 3'd2;
	localparam logic [2:0] CFG_REQUEST_TYPE  = 3'd3;
	localparam logic [2:0] CFG_RESPONSE_TYPE = 3'd4;
	localparam logic [2:0] CFG_FRAME_TIMEOUT = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Frame event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_GOOD = 2'd1;
	localparam logic [1:0] EV_BAD  = 2'd2;

	// Reported mode codes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_SAW   = 2'd1;
	localparam logic [1:0] MODE_ARMED = 2'd2;

	// Command classes between front and back
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_DEV  = 3'd1,
		OP_HOST = 3'd2,
		OP_TIME = 3'd3,
		OP_TAKE = 3'd4,
		OP_SOFT = 3'd5
	} sad_op_kind_t;

	typedef struct packed {
		sad_op_kind_t op;
		logic [7:0]   data_byte;
		logic [31:0]  now_ms;
	} sad_op_t;

	// Deframer scan phase
	typedef enum logic [4:0] {
		PH_SOF  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_TYPE = 5'b00100,
		PH_CMD  = 5'b01000,
		PH_BODY = 5'b10000
	} sad_phase_t;

	// Detector mode
	typedef enum logic [2:0] {
		MD_IDLE  = 3'b001,
		MD_SAW   = 3'b010,
		MD_ARMED = 3'b100
	} sad_mode_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  min_length;
		logic [7:0]  checksum_seed;
		logic [7:0]  request_type;
		logic [7:0]  response_type;
		logic [15:0] frame_timeout_ms;
	} sad_cfg_t;

	// Controls for one deframer
	typedef struct packed {
		logic        feed;
		logic        expire;
		logic        clear;
		logic [7:0]  data_byte;
		logic [31:0] now_ms;
	} sad_dfr_ctl_t;

	function automatic logic [1:0] mode_code(sad_mode_t m);
		logic [1:0] c;
		case (m)
			MD_SAW:   c = MODE_SAW;
			MD_ARMED: c = MODE_ARMED;
			default:  c = MODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/sad_in_if.sv
// Input channel: valid/ready with kind, data byte and time stamp.
interface sad_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] now_ms;

	modport source (output valid, output kind, output data_byte, output now_ms, input ready);
	modport sink   (input valid, input kind, input data_byte, input now_ms, output ready);
endinterface

>>> hw/rtl/sad_out_if.sv
// Result channel: valid/ready with frame event, ack flag and mode.
interface sad_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_event;
	logic       ack_given;
	logic [1:0] mode;

	modport source (output valid, output frame_event, output ack_given, output mode, input ready);
	modport sink   (input valid, input frame_event, input ack_given, input mode, output ready);
endinterface

>>> hw/rtl/serial_api_exchange_detector.sv
// Top level of the serial API exchange detector: config registers, front, queue, back.
//
// Watches both directions of a framed serial link. Items carry a device
// byte, a host byte, a millisecond time stamp, a take-ack request or a soft
// reset; every accepted item returns exactly one result with the fed
// deframer's event, the ack flag and the detector mode after the item.
// Throughput is one item per clock while results are taken: the front
// classifies an item in the cycle it is accepted and writes it into a
// two-entry queue, and the back pops one command a cycle whenever the
// output register is empty or being taken, updating both deframers and
// the detector as it pops. The result register loads when the back pops
// the item, after it was written into the queue; the result then sits in
// the output register, the queue keeps accepting while it waits, and ready
// drops only once both queue entries are occupied. The user is to write
// the configuration registers through cfg_we/cfg_index/cfg_wdata only
// while the block is idle (not enforced); writes to unused indexes are ignored.
module serial_api_exchange_detector #(
	parameter int REJECT_LIMIT = 4   // malformed device frames in a row that disarm, 1..7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sad_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sad_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	sad_in_if.sink                            link,
	sad_out_if.source                         result
);
	import sad_pkg::*;

	sad_cfg_t cfg_q;
	logic     q_full;
	logic     q_valid;
	logic     push;
	logic     pop;
	sad_op_t  front_op;
	sad_op_t  q_op;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte       <= 8'd1;
			cfg_q.min_length       <= 8'd3;
			cfg_q.checksum_seed    <= 8'd255;
			cfg_q.request_type     <= 8'd0;
			cfg_q.response_type    <= 8'd1;
			cfg_q.frame_timeout_ms <= 16'd1500;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_BYTE:    cfg_q.start_byte       <= cfg_wdata[7:0];
				CFG_MIN_LENGTH:    cfg_q.min_length       <= cfg_wdata[7:0];
				CFG_CHECKSUM_SEED: cfg_q.checksum_seed    <= cfg_wdata[7:0];
				CFG_REQUEST_TYPE:  cfg_q.request_type     <= cfg_wdata[7:0];
				CFG_RESPONSE_TYPE: cfg_q.response_type    <= cfg_wdata[7:0];
				CFG_FRAME_TIMEOUT: cfg_q.frame_timeout_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	sad_front u_front (
		.link   (link),
		.q_full (q_full),
		.push   (push),
		.op     (front_op)
	);

	// decoupling queue
	sad_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_op),
		.pop    (pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_op)
	);

	// back: deframers, detector, result register
	sad_back #(
		.REJECT_LIMIT (REJECT_LIMIT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop),
		.result  (result)
	);
endmodule

>>> hw/rtl/sad_front.sv
// Front end: accepts items and classifies them into commands for the queue.
module sad_front (
	sad_in_if.sink         link,
	input  logic           q_full,
	output logic           push,
	output sad_pkg::sad_op_t op
);
	import sad_pkg::*;

	assign link.ready = !q_full;
	assign push       = link.valid && !q_full;

	always_comb begin
		op.data_byte = link.data_byte;
		op.now_ms    = link.now_ms;
		case (link.kind)
			KIND_DEV_BYTE:  op.op = OP_DEV;
			KIND_HOST_BYTE: op.op = OP_HOST;
			KIND_TIME:      op.op = OP_TIME;
			KIND_TAKE_ACK:  op.op = OP_TAKE;
			KIND_SOFT_RST:  op.op = OP_SOFT;
			default:        op.op = OP_NONE;
		endcase
	end
endmodule

>>> hw/rtl/sad_queue.sv
// Two-entry command queue between front and back.
module sad_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sad_pkg::sad_op_t wdata,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output sad_pkg::sad_op_t rdata
);
	import sad_pkg::*;

	sad_op_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> hw/rtl/sad_deframer.sv
// One direction's deframer: start, length, type, command, body, XOR checksum.
module sad_deframer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sad_pkg::sad_cfg_t     cfg,
	input  sad_pkg::sad_dfr_ctl_t ctl,
	output logic [1:0]            frame_event,
	output logic [7:0]            frm_type,
	output logic [7:0]            frm_cmd
);
	import sad_pkg::*;

	sad_phase_t  phase_q;
	logic [7:0]  left_q;
	logic [7:0]  sum_q;
	logic [7:0]  type_q;
	logic [7:0]  cmd_q;
	logic [31:0] start_q;

	sad_phase_t  phase_d;
	logic [7:0]  left_d;
	logic [7:0]  sum_d;
	logic [7:0]  type_d;
	logic [7:0]  cmd_d;
	logic [31:0] start_d;
	logic [31:0] elapsed;
	logic [7:0]  b;

	assign frm_type = type_q;
	assign frm_cmd  = cmd_q;
	assign b        = ctl.data_byte;
	assign elapsed  = ctl.now_ms - start_q;

	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		sum_d       = sum_q;
		type_d      = type_q;
		cmd_d       = cmd_q;
		start_d     = start_q;
		frame_event = EV_NONE;
		if (ctl.clear) begin
			phase_d = PH_SOF;
			left_d  = 8'd0;
			sum_d   = 8'd0;
			type_d  = 8'd0;
			cmd_d   = 8'd0;
		end else if (ctl.feed) begin
			case (phase_q)
				PH_SOF: begin
					if (b == cfg.start_byte) begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b < cfg.min_length) begin
						// short length; a start byte here reopens the frame
						phase_d     = (b == cfg.start_byte) ? PH_LEN : PH_SOF;
						frame_event = EV_BAD;
					end else begin
						left_d  = b;
						sum_d   = cfg.checksum_seed ^ b;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d  = b;
					sum_d   = sum_q ^ b;
					left_d  = left_q - 8'd1;
					phase_d = PH_CMD;
				end
				PH_CMD: begin
					cmd_d   = b;
					sum_d   = sum_q ^ b;
					left_d  = left_q - 8'd1;
					phase_d = PH_BODY;
				end
				PH_BODY: begin
					if (left_q > 8'd1) begin
						sum_d  = sum_q ^ b;
						left_d = left_q - 8'd1;
					end else begin
						phase_d     = PH_SOF;
						frame_event = (b == sum_q) ? EV_GOOD : EV_BAD;
					end
				end
				default: phase_d = PH_SOF;
			endcase
		end else if (ctl.expire) begin
			if (phase_q == PH_SOF) begin
				start_d = ctl.now_ms;
			end else if (elapsed > {16'd0, cfg.frame_timeout_ms}) begin
				phase_d = PH_SOF;
				left_d  = 8'd0;
				sum_d   = 8'd0;
				type_d  = 8'd0;
				cmd_d   = 8'd0;
				start_d = ctl.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOF;
			left_q  <= 8'd0;
			sum_q   <= 8'd0;
			type_q  <= 8'd0;
			cmd_q   <= 8'd0;
			start_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			type_q  <= type_d;
			cmd_q   <= cmd_d;
			start_q <= start_d;
		end
	end
endmodule

>>> hw/rtl/sad_back.sv
// Back end: runs commands through both deframers and the detector, holds the result.
module sad_back #(
	parameter int REJECT_LIMIT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sad_pkg::sad_cfg_t cfg,
	input  logic              q_valid,
	input  sad_pkg::sad_op_t  q_op,
	output logic              pop,
	sad_out_if.source         result
);
	import sad_pkg::*;

	sad_mode_t   mode_q;
	logic [7:0]  awaited_q;
	logic        ack_q;
	logic [2:0]  rej_q;
	logic        out_valid_q;
	logic [1:0]  out_event_q;
	logic        out_ack_q;
	logic [1:0]  out_mode_q;

	sad_mode_t    mode_d;
	logic [7:0]   awaited_d;
	logic         ack_d;
	logic [2:0]   rej_d;
	logic [2:0]   rej_inc;
	logic [1:0]   ev;
	logic         given;
	sad_dfr_ctl_t dev_ctl;
	sad_dfr_ctl_t host_ctl;
	logic [1:0]   dev_ev;
	logic [1:0]   host_ev;
	logic [7:0]   dev_type;
	logic [7:0]   dev_cmd;
	logic [7:0]   host_type;
	logic [7:0]   host_cmd;

	assign pop     = q_valid && (!out_valid_q || result.ready);
	assign rej_inc = rej_q + 3'd1;

	sad_deframer u_dev (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.ctl         (dev_ctl),
		.frame_event (dev_ev),
		.frm_type    (dev_type),
		.frm_cmd     (dev_cmd)
	);

	sad_deframer u_host (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.ctl         (host_ctl),
		.frame_event (host_ev),
		.frm_type    (host_type),
		.frm_cmd     (host_cmd)
	);

	always_comb begin
		dev_ctl.feed       = pop && (q_op.op == OP_DEV);
		dev_ctl.expire     = pop && (q_op.op == OP_TIME);
		dev_ctl.clear      = pop && (q_op.op == OP_SOFT);
		dev_ctl.data_byte  = q_op.data_byte;
		dev_ctl.now_ms     = q_op.now_ms;
		host_ctl.feed      = pop && (q_op.op == OP_HOST);
		host_ctl.expire    = pop && (q_op.op == OP_TIME);
		host_ctl.clear     = pop && (q_op.op == OP_SOFT);
		host_ctl.data_byte = q_op.data_byte;
		host_ctl.now_ms    = q_op.now_ms;

		mode_d    = mode_q;
		awaited_d = awaited_q;
		ack_d     = ack_q;
		rej_d     = rej_q;
		ev        = EV_NONE;
		given     = 1'b0;

		case (q_op.op)
			OP_DEV: begin
				ev = dev_ev;
				if (dev_ev == EV_GOOD) begin
					if (mode_q == MD_SAW) begin
						if (dev_type == cfg.response_type && dev_cmd == awaited_q) begin
							mode_d        = MD_ARMED;
							host_ctl.clear = pop;
							ack_d         = 1'b1;
							rej_d         = 3'd0;
						end
					end else if (mode_q == MD_ARMED) begin
						ack_d = 1'b1;
						rej_d = 3'd0;
					end
				end else if (dev_ev == EV_BAD && mode_q == MD_ARMED) begin
					if (rej_inc >= 3'(REJECT_LIMIT)) begin
						mode_d = MD_IDLE;
						rej_d  = 3'd0;
						ack_d  = 1'b0;
					end else begin
						rej_d = rej_inc;
					end
				end
			end
			OP_HOST: begin
				ev = host_ev;
				if (host_ev == EV_GOOD && mode_q != MD_ARMED && host_type == cfg.request_type) begin
					awaited_d = host_cmd;
					mode_d    = MD_SAW;
				end
			end
			OP_TAKE: begin
				given = ack_q;
				ack_d = 1'b0;
			end
			OP_SOFT: begin
				mode_d    = MD_IDLE;
				awaited_d = 8'd0;
				ack_d     = 1'b0;
				rej_d     = 3'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MD_IDLE;
			awaited_q   <= 8'd0;
			ack_q       <= 1'b0;
			rej_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q    <= mode_d;
				awaited_q <= awaited_d;
				ack_q     <= ack_d;
				rej_q     <= rej_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_event_q <= ev;
			out_ack_q   <= given;
			out_mode_q  <= mode_code(mode_d);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.frame_event = out_event_q;
	assign result.ack_given   = out_ack_q;
	assign result.mode        = out_mode_q;
endmodule

>>> sim/sad_result_check.sv
// Result checker for the serial API exchange detector: predicts each item's outcome and compares.
module sad_result_check #(
	parameter int REJECT_LIMIT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	sad_in_if                               link,
	sad_out_if                              result,
	output int                              fail_count,
	output int                              pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import sad_pkg::*;

	localparam int DEV  = 0;
	localparam int HOST = 1;
	localparam int PRINT_CAP = 100;

	typedef struct {
		sad_phase_t  phase;
		logic [7:0]  left;
		logic [7:0]  sum;
		logic [7:0]  frame_type;
		logic [7:0]  frame_cmd;
		logic [31:0] started;
	} scan_state_t;

	typedef struct packed {
		logic [1:0] frame_event;
		logic       ack_given;
		logic [1:0] mode;
	} outcome_t;

	sad_cfg_t    regs;
	scan_state_t scan [2];
	logic [1:0]  det_mode;
	logic [7:0]  awaited_cmd;
	logic        ack_owed;
	logic [2:0]  rejects;
	outcome_t    outcome_q [$];

	function automatic void clear_scan(int d);
		scan[d].phase = PH_SOF;
		scan[d].left = '0;
		scan[d].sum = '0;
		scan[d].frame_type = '0;
		scan[d].frame_cmd = '0;
	endfunction

	function automatic void soft_clear();
		clear_scan(DEV);
		clear_scan(HOST);
		det_mode = MODE_IDLE;
		awaited_cmd = '0;
		ack_owed = 1'b0;
		rejects = '0;
	endfunction

	function automatic void reset_model();
		regs.start_byte = 8'd1;
		regs.min_length = 8'd3;
		regs.checksum_seed = 8'd255;
		regs.request_type = 8'd0;
		regs.response_type = 8'd1;
		regs.frame_timeout_ms = 16'd1500;
		scan[DEV].started = '0;
		scan[HOST].started = '0;
		soft_clear();
	endfunction

	function automatic void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_START_BYTE:    regs.start_byte = val[7:0];
			CFG_MIN_LENGTH:    regs.min_length = val[7:0];
			CFG_CHECKSUM_SEED: regs.checksum_seed = val[7:0];
			CFG_REQUEST_TYPE:  regs.request_type = val[7:0];
			CFG_RESPONSE_TYPE: regs.response_type = val[7:0];
			CFG_FRAME_TIMEOUT: regs.frame_timeout_ms = val;
			default: ;
		endcase
	endfunction

	// One byte into a deframer; returns the frame event
	function automatic logic [1:0] feed_byte(int d, logic [7:0] b);
		logic [1:0] ev;
		ev = EV_NONE;
		case (scan[d].phase)
			PH_SOF: begin
				if (b == regs.start_byte)
					scan[d].phase = PH_LEN;
			end
			PH_LEN: begin
				if (b < regs.min_length) begin
					// start byte in length slot keeps waiting for a length
					scan[d].phase = (b == regs.start_byte) ? PH_LEN : PH_SOF;
					ev = EV_BAD;
				end else begin
					scan[d].left = b;
					scan[d].sum = regs.checksum_seed ^ b;
					scan[d].phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				scan[d].frame_type = b;
				scan[d].sum ^= b;
				scan[d].left -= 8'd1;
				scan[d].phase = PH_CMD;
			end
			PH_CMD: begin
				scan[d].frame_cmd = b;
				scan[d].sum ^= b;
				scan[d].left -= 8'd1;
				scan[d].phase = PH_BODY;
			end
			default: begin
				if (scan[d].left > 8'd1) begin
					scan[d].sum ^= b;
					scan[d].left -= 8'd1;
				end else begin
					scan[d].phase = PH_SOF;
					ev = (b == scan[d].sum) ? EV_GOOD : EV_BAD;
				end
			end
		endcase
		return ev;
	endfunction

	function automatic void age_out(int d, logic [31:0] now);
		logic [31:0] elapsed;
		elapsed = now - scan[d].started;
		if (scan[d].phase != PH_SOF) begin
			if (elapsed <= {16'd0, regs.frame_timeout_ms})
				return;
			clear_scan(d);
		end
		scan[d].started = now;
	endfunction

	function automatic void dev_frame_good();
		if (det_mode == MODE_SAW) begin
			if (scan[DEV].frame_type != regs.response_type || scan[DEV].frame_cmd != awaited_cmd)
				return;
			det_mode = MODE_ARMED;
			clear_scan(HOST);
		end else if (det_mode != MODE_ARMED) begin
			return;
		end
		ack_owed = 1'b1;
		rejects = '0;
	endfunction

	function automatic void dev_frame_bad();
		if (det_mode != MODE_ARMED)
			return;
		rejects = rejects + 3'd1;
		if (rejects >= REJECT_LIMIT) begin
			det_mode = MODE_IDLE;
			rejects = '0;
			ack_owed = 1'b0;
		end
	endfunction

	function automatic outcome_t predict(logic [2:0] kind, logic [7:0] b, logic [31:0] now);
		outcome_t o;
		o = '0;
		case (kind)
			KIND_DEV_BYTE: begin
				o.frame_event = feed_byte(DEV, b);
				if (o.frame_event == EV_GOOD)
					dev_frame_good();
				else if (o.frame_event == EV_BAD)
					dev_frame_bad();
			end
			KIND_HOST_BYTE: begin
				o.frame_event = feed_byte(HOST, b);
				if (o.frame_event == EV_GOOD && det_mode != MODE_ARMED &&
						scan[HOST].frame_type == regs.request_type) begin
					awaited_cmd = scan[HOST].frame_cmd;
					det_mode = MODE_SAW;
				end
			end
			KIND_TIME: begin
				age_out(DEV, now);
				age_out(HOST, now);
			end
			KIND_TAKE_ACK: begin
				o.ack_given = ack_owed;
				ack_owed = 1'b0;
			end
			KIND_SOFT_RST: soft_clear();
			default: ;
		endcase
		o.mode = det_mode;
		return o;
	endfunction

	// Prints are capped so a broken block cannot flood the log; every one is counted
	task automatic report_mismatch(string what);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic check_result();
		outcome_t want;
		if (outcome_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result event=%0d ack=%0d mode=%0d",
				result.frame_event, result.ack_given, result.mode));
			return;
		end
		want = outcome_q.pop_front();
		if (result.frame_event !== want.frame_event)
			report_mismatch($sformatf("frame_event got %0d want %0d",
				result.frame_event, want.frame_event));
		if (result.ack_given !== want.ack_given)
			report_mismatch($sformatf("ack_given got %0d want %0d",
				result.ack_given, want.ack_given));
		if (result.mode !== want.mode)
			report_mismatch($sformatf("mode got %0d want %0d", result.mode, want.mode));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			outcome_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_wdata);
			if (link.valid && link.ready)
				outcome_q.push_back(predict(link.kind, link.data_byte, link.now_ms));
			if (result.valid && result.ready)
				check_result();
			pending_count = outcome_q.size();
		end
	end

endmodule

>>> sim/serial_api_exchange_detector_test.sv
// Testbench top for the serial API exchange detector: stimulus, idling, watchdog and verdict.
module serial_api_exchange_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sad_pkg::*;

	localparam int REJECT_LIMIT = 4;
	localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
	localparam int SEG_ITEMS    = 160;
	localparam int LONG_ITEMS   = 400;    // segment with 255-byte minimum length
	localparam int NUM_SEGS     = 6;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	typedef enum {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_CUT, FRAME_SHORT} frame_flaw_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	sad_in_if  link_ch();
	sad_out_if result_ch();

	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          time_mix_pct;     // chance of a time item slipped between frame bytes
	int          items_sent;
	int          stall_cycles = 0;
	sad_cfg_t    cur;              // settings the block holds right now
	logic [31:0] clock_ms;
	logic [7:0]  last_req_cmd;

	serial_api_exchange_detector #(.REJECT_LIMIT(REJECT_LIMIT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.link      (link_ch),
		.result    (result_ch)
	);

	sad_result_check #(.REJECT_LIMIT(REJECT_LIMIT)) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.link          (link_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side back-pressure, one decision per clock
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: a run that stops moving is a failure
	always @(posedge clk) begin
		if ((link_ch.valid && link_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// One item on the link. Ready is sampled at the falling edge, where it is
	// settled for the next rising edge, so the handshake is seen race-free.
	task automatic send_item(logic [2:0] kind, logic [7:0] b, logic [31:0] now);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			link_ch.valid <= 1'b0;
			@(posedge clk);
		end
		link_ch.valid <= 1'b1;
		link_ch.kind <= kind;
		link_ch.data_byte <= b;
		link_ch.now_ms <= now;
		do begin
			@(negedge clk);
			took = link_ch.ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	// Byte items carry a random, ignored time stamp
	task automatic send_byte(logic [2:0] kind, logic [7:0] b);
		send_item(kind, b, $urandom);
	endtask

	// Advance the millisecond clock. Near steps of up to 40 ms stay inside a
	// longer window; far steps hit the timeout edge, overshoot it, jump anywhere or go to wrap.
	task automatic send_time(logic far);
		logic [31:0] step;
		step = 32'($urandom_range(0, 40));
		if (far) begin
			case ($urandom_range(3))
				0: step = 32'(cur.frame_timeout_ms) + 32'($urandom_range(0, 2)) - 32'd1;
				1: step = 32'(cur.frame_timeout_ms) + 32'($urandom_range(1, 5000));
				2: step = $urandom - clock_ms;
				default: step = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000)) - clock_ms;
			endcase
		end
		clock_ms += step;
		send_item(KIND_TIME, 8'($urandom), clock_ms);
	endtask

	// Whole or damaged frame in one direction, built from the current settings
	task automatic send_frame(logic [2:0] kind, logic [7:0] len, logic [7:0] ftype,
			logic [7:0] fcmd, frame_flaw_t flaw);
		logic [7:0] bytes_q [$];
		logic [7:0] sum;
		logic [7:0] left;
		logic [7:0] b;
		int         body;
		int         n;
		if (flaw == FRAME_SHORT) begin
			// length under the minimum; sometimes the start byte itself
			len = 8'($urandom_range(0, int'(cur.min_length) - 1));
			if (cur.start_byte < cur.min_length && $urandom_range(1))
				len = cur.start_byte;
			send_byte(kind, cur.start_byte);
			send_byte(kind, len);
			return;
		end
		bytes_q = {cur.start_byte, len, ftype, fcmd};
		sum = cur.checksum_seed ^ len ^ ftype ^ fcmd;
		// lengths under two wrap the byte count, giving a long body
		left = len - 8'd2;
		body = (left > 8'd1) ? int'(left) - 1 : 0;
		repeat (body) begin
			b = 8'($urandom);
			sum ^= b;
			bytes_q.push_back(b);
		end
		bytes_q.push_back((flaw == FRAME_BAD_SUM) ? sum ^ (8'd1 << $urandom_range(7)) : sum);
		n = (flaw == FRAME_CUT) ? $urandom_range(1, bytes_q.size() - 1) : bytes_q.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < time_mix_pct)
				send_time(1'b0);
			send_byte(kind, bytes_q[i]);
		end
		// a stalled partial frame usually gets aged out
		if (flaw == FRAME_CUT && $urandom_range(1))
			send_time(1'b1);
	endtask

	function automatic logic [7:0] pick_len();
		int lo;
		lo = (cur.min_length < 8'd3) ? 3 : int'(cur.min_length);
		if (cur.min_length < 8'd3 && $urandom_range(19) == 0)
			return 8'($urandom_range(int'(cur.min_length), 2));
		return 8'($urandom_range(lo, (lo + 5 > 255) ? 255 : lo + 5));
	endfunction

	function automatic frame_flaw_t pick_flaw();
		case ($urandom_range(11))
			0: return FRAME_BAD_SUM;
			1: return FRAME_CUT;
			2: return (cur.min_length > 8'd0) ? FRAME_SHORT : FRAME_BAD_SUM;
			default: return FRAME_CLEAN;
		endcase
	endfunction

	// Mostly request/response exchanges with random content, plus acks,
	// reject runs, time items, soft resets and raw noise.
	task automatic run_exchanges(int count);
		int          stop_at;
		int          pick;
		logic [7:0]  ft;
		logic [7:0]  fc;
		frame_flaw_t flaw;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 26) begin
				ft = ($urandom_range(7) == 0) ? 8'($urandom) : cur.request_type;
				fc = 8'($urandom_range(3));
				if (ft == cur.request_type)
					last_req_cmd = fc;
				send_frame(KIND_HOST_BYTE, pick_len(), ft, fc, pick_flaw());
			end else if (pick < 56) begin
				ft = ($urandom_range(5) == 0) ? 8'($urandom) : cur.response_type;
				fc = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : last_req_cmd;
				send_frame(KIND_DEV_BYTE, pick_len(), ft, fc, pick_flaw());
			end else if (pick < 61) begin
				// run of malformed device frames, often long enough to disarm
				repeat ($urandom_range(2, 5)) begin
					flaw = (cur.min_length > 8'd0 && $urandom_range(1)) ? FRAME_SHORT
						: FRAME_BAD_SUM;
					send_frame(KIND_DEV_BYTE, pick_len(), cur.response_type, last_req_cmd, flaw);
				end
			end else if (pick < 71) begin
				send_time(1'b1);
			end else if (pick < 80) begin
				send_time(1'b0);
			end else if (pick < 88) begin
				send_item(KIND_TAKE_ACK, 8'($urandom), $urandom);
			end else if (pick < 90) begin
				send_item(KIND_SOFT_RST, 8'($urandom), $urandom);
			end else if (pick < 92) begin
				send_item(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(3'($urandom_range(0, 1)), 8'($urandom));
			end
		end
	endtask

	// Sender pauses until every result has come back, then lets the pipeline settle
	task automatic drain_results();
		link_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
	endtask

	// All six registers, upper data bits of byte registers filled with junk
	task automatic load_settings(sad_cfg_t s);
		logic [CFG_INDEX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0]  val [6];
		idx[0] = CFG_START_BYTE;    val[0] = {8'($urandom), s.start_byte};
		idx[1] = CFG_MIN_LENGTH;    val[1] = {8'($urandom), s.min_length};
		idx[2] = CFG_CHECKSUM_SEED; val[2] = {8'($urandom), s.checksum_seed};
		idx[3] = CFG_REQUEST_TYPE;  val[3] = {8'($urandom), s.request_type};
		idx[4] = CFG_RESPONSE_TYPE; val[4] = {8'($urandom), s.response_type};
		idx[5] = CFG_FRAME_TIMEOUT; val[5] = s.frame_timeout_ms;
		cfg_we <= 1'b1;
		for (int i = 0; i < 6; i++) begin
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur = s;
	endtask

	// Segment settings: reset values, all-low, all-high, then random mixes
	function automatic sad_cfg_t settings_for(int seg);
		sad_cfg_t s;
		case (seg)
			0: s = {8'd1, 8'd3, 8'd255, 8'd0, 8'd1, 16'd1500};
			1: s = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};
			2: s = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535};
			default: begin
				s.start_byte = 8'($urandom);
				s.min_length = 8'($urandom_range(0, 8));
				s.checksum_seed = 8'($urandom);
				s.request_type = 8'($urandom);
				// request and response types sometimes coincide
				s.response_type = $urandom_range(3) ? 8'($urandom) : s.request_type;
				s.frame_timeout_ms = (seg == 3) ? 16'($urandom_range(0, 300)) : 16'($urandom);
			end
		endcase
		return s;
	endfunction

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		link_ch.valid <= 1'b0;
		link_ch.kind <= '0;
		link_ch.data_byte <= '0;
		link_ch.now_ms <= '0;
		cur = settings_for(0);
		clock_ms = '0;
		last_req_cmd = '0;
		items_sent = 0;
		time_mix_pct = 0;
		send_idle_pct = 11;
		recv_idle_pct = 58;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset settings ---
		// host request then matching device response: detector arms, ack owed
		send_frame(KIND_HOST_BYTE, 8'd3, cur.request_type, 8'h13, FRAME_CLEAN);
		send_frame(KIND_DEV_BYTE, 8'd3, cur.response_type, 8'h13, FRAME_CLEAN);
		// ack taken once, then nothing left to give
		send_item(KIND_TAKE_ACK, 8'hFF, 32'hFFFF_FFFF);
		send_item(KIND_TAKE_ACK, 8'h00, 32'h0000_0000);
		// start byte used as a short length keeps the deframer on the length
		send_byte(KIND_DEV_BYTE, cur.start_byte);
		send_byte(KIND_DEV_BYTE, cur.start_byte);
		send_byte(KIND_DEV_BYTE, cur.start_byte);
		send_byte(KIND_DEV_BYTE, 8'h00);
		// fourth malformed frame in a row disarms
		send_byte(KIND_DEV_BYTE, cur.start_byte);
		send_byte(KIND_DEV_BYTE, 8'h02);
		// partial frame: within the window at the edge, abandoned one past it
		send_item(KIND_TIME, 8'h00, 32'd0);
		send_byte(KIND_DEV_BYTE, cur.start_byte);
		send_item(KIND_TIME, 8'h00, 32'd1500);
		send_item(KIND_TIME, 8'h00, 32'd1501);
		send_item(KIND_TIME, 8'hFF, 32'hFFFF_FFFF);
		// unused kind changes nothing; soft reset clears the detector
		send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		send_item(KIND_SOFT_RST, 8'h00, 32'h0000_0000);
		drain_results();

		// --- random part: sender/receiver idling regimes two segments each ---
		time_mix_pct = 3;
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_settings(settings_for(seg));
			run_exchanges((seg == 2) ? LONG_ITEMS : SEG_ITEMS);
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
